### hdl/signed_decimal_formatter_macros.svh
// Assertion macros for the checker file of this block.
`ifndef SIGNED_DECIMAL_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sdf_pkg.sv
`default_nettype none
package sdf_pkg;

    // Magnitude width and width of the double-dabble step counter
    localparam int MAG_W  = 64;
    localparam int IT_W   = 6;
    // BCD digits held by the converter, and bits for a digit count
    localparam int NDIG   = 20;
    localparam int DCNT_W = 5;

    // size_mode codes
    localparam logic [1:0] SZ_INT   = 2'd0;
    localparam logic [1:0] SZ_SHORT = 2'd1;
    localparam logic [1:0] SZ_CHAR  = 2'd2;
    localparam logic [1:0] SZ_LONG  = 2'd3;

    // ASCII codes
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_PLAN,
        ST_LPAD,
        ST_SIGN,
        ST_ZPAD,
        ST_PREC,
        ST_DIGIT,
        ST_RPAD
    } state_t;

    typedef enum logic [2:0] {
        EM_SPACE,
        EM_SIGN,
        EM_FILL,
        EM_PREC,
        EM_DIGIT
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      size;
        logic      plan;
        logic      emit;
        emit_sel_t emit_sel;
    } sdf_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic pad_zero;
        logic prec_zero;
        logic dig_zero;
        logic has_sign;
        logic left;
        logic zfill;
        logic out_free;
    } sdf_sts_t;

endpackage
`default_nettype wire

### hdl/sdf_in_if.sv
`default_nettype none
interface sdf_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [1:0]         size_mode;
    logic               force_sign;
    logic               space_sign;
    logic               left_align;
    logic               zero_pad;
    logic               precision_given;
    logic [5:0]         precision;
    logic [5:0]         width;

    modport source (
        output valid, value, size_mode, force_sign, space_sign, left_align,
               zero_pad, precision_given, precision, width,
        input  ready
    );
    modport sink (
        input  valid, value, size_mode, force_sign, space_sign, left_align,
               zero_pad, precision_given, precision, width,
        output ready
    );
endinterface
`default_nettype wire

### hdl/sdf_out_if.sv
`default_nettype none
interface sdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (
        output valid, char_code, last,
        input  ready
    );
    modport sink (
        input  valid, char_code, last,
        output ready
    );
endinterface
`default_nettype wire

### hdl/sdf_ctrl.sv
`default_nettype none
module sdf_ctrl
    import sdf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire sdf_sts_t sts,
    output sdf_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.emit_sel = EM_SPACE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_done)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = ST_LPAD;
            end
            ST_LPAD:
            begin
                cmd.emit_sel = EM_SPACE;
                if (sts.left || sts.zfill || sts.pad_zero)
                begin
                    state_next = ST_SIGN;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sel = EM_SIGN;
                if (!sts.has_sign)
                begin
                    state_next = ST_ZPAD;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ZPAD;
                end
            end
            ST_ZPAD:
            begin
                cmd.emit_sel = EM_FILL;
                if (!sts.zfill || sts.pad_zero)
                begin
                    state_next = ST_PREC;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_PREC:
            begin
                cmd.emit_sel = EM_PREC;
                if (sts.prec_zero)
                begin
                    state_next = ST_DIGIT;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_DIGIT:
            begin
                cmd.emit_sel = EM_DIGIT;
                if (sts.dig_zero)
                begin
                    state_next = ST_RPAD;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            ST_RPAD:
            begin
                cmd.emit_sel = EM_SPACE;
                if (!sts.left || sts.pad_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/sdf_dp.sv
`default_nettype none
module sdf_dp
    import sdf_pkg::*;
#(
    parameter int FIELD_MAX = 63
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdf_cmd_t           cmd,
    output sdf_sts_t                sts,
    input  wire logic signed [63:0] value,
    input  wire logic [1:0]         size_mode,
    input  wire logic               force_sign,
    input  wire logic               space_sign,
    input  wire logic               left_align,
    input  wire logic               zero_pad,
    input  wire logic               precision_given,
    input  wire logic [5:0]         precision,
    input  wire logic [5:0]         width,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              char_code,
    output logic                    last
);

    // Counts up to FIELD_MAX + 1 characters and holds a raw 6-bit field
    localparam int CW = $clog2(FIELD_MAX + 65);
    localparam logic [CW-1:0] LIMIT = CW'(FIELD_MAX);

    logic [MAG_W-1:0]    bin_reg;
    logic [NDIG*4-1:0]   bcd_reg;
    logic [IT_W-1:0]     iter_reg;
    logic                neg_reg;
    logic                plus_reg;
    logic                space_reg;
    logic                left_reg;
    logic                zfill_reg;
    logic                zprec_reg;
    logic [CW-1:0]       prec_reg;
    logic [CW-1:0]       wid_reg;
    logic [DCNT_W-1:0]   nd_reg;
    logic [CW-1:0]       nz_reg;
    logic [CW-1:0]       pad_reg;
    logic [CW-1:0]       rem_reg;
    logic [7:0]          char_reg;
    logic                last_reg;
    logic                valid_reg;

    logic [MAG_W-1:0]    ext;
    logic [MAG_W-1:0]    mag;
    logic [CW-1:0]       prec_in;
    logic [CW-1:0]       wid_in;
    logic [NDIG*4-1:0]   bcd_adj;
    logic [3:0]          dig_arr [NDIG];
    logic [DCNT_W-1:0]   top;
    logic [DCNT_W-1:0]   nd_calc;
    logic [DCNT_W-1:0]   dig_idx;
    logic                has_sign;
    logic [CW-1:0]       nd_ext;
    logic [CW-1:0]       nz_calc;
    logic [CW-1:0]       body;
    logic [CW-1:0]       pad_calc;
    logic [CW-1:0]       total;
    logic [7:0]          sign_char;
    logic [7:0]          emit_char;
    logic                out_free;

    // Sign-extend from the selected length, then take the magnitude
    always_comb
    begin
        case (size_mode)
            SZ_INT:   ext = {{32{value[31]}}, value[31:0]};
            SZ_SHORT: ext = {{48{value[15]}}, value[15:0]};
            SZ_CHAR:  ext = {{56{value[7]}}, value[7:0]};
            SZ_LONG:  ext = value;
            default:  ext = value;
        endcase
        mag     = ext[MAG_W-1] ? (MAG_W'(0) - ext) : ext;
        prec_in = (CW'(precision) > LIMIT) ? LIMIT : CW'(precision);
        wid_in  = (CW'(width) > LIMIT) ? LIMIT : CW'(width);
    end

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            dig_arr[i] = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    // Highest nonzero digit
    always_comb
    begin
        top = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_arr[i] != 4'd0)
            begin
                top = DCNT_W'(i + 1);
            end
        end
        if (top == '0)
        begin
            nd_calc = zprec_reg ? DCNT_W'(0) : DCNT_W'(1);
        end
        else
        begin
            nd_calc = top;
        end
    end

    // Field layout
    always_comb
    begin
        has_sign = neg_reg || plus_reg || space_reg;
        nd_ext   = CW'(nd_reg);
        nz_calc  = (prec_reg > nd_ext) ? (prec_reg - nd_ext) : '0;
        body     = CW'(has_sign) + nz_calc + nd_ext;
        pad_calc = (wid_reg > body) ? (wid_reg - body) : '0;
        total    = (wid_reg > body) ? wid_reg : body;
    end

    // Character to emit
    always_comb
    begin
        dig_idx = nd_reg - DCNT_W'(1);
        if (neg_reg)
        begin
            sign_char = ASCII_MINUS;
        end
        else if (plus_reg)
        begin
            sign_char = ASCII_PLUS;
        end
        else
        begin
            sign_char = ASCII_SPACE;
        end
        case (cmd.emit_sel)
            EM_SPACE: emit_char = ASCII_SPACE;
            EM_SIGN:  emit_char = sign_char;
            EM_FILL:  emit_char = ASCII_ZERO;
            EM_PREC:  emit_char = ASCII_ZERO;
            EM_DIGIT: emit_char = ASCII_ZERO | {4'h0, dig_arr[dig_idx]};
            default:  emit_char = ASCII_SPACE;
        endcase
    end

    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg   <= mag;
            bcd_reg   <= '0;
            neg_reg   <= ext[MAG_W-1];
            plus_reg  <= force_sign;
            space_reg <= space_sign;
            left_reg  <= left_align;
            zfill_reg <= !left_align && zero_pad && !precision_given;
            zprec_reg <= precision_given && (precision == 6'd0);
            prec_reg  <= prec_in;
            wid_reg   <= wid_in;
        end
        else if (cmd.conv_step)
        begin
            bcd_reg <= {bcd_adj[NDIG*4-2:0], bin_reg[MAG_W-1]};
            bin_reg <= {bin_reg[MAG_W-2:0], 1'b0};
        end
        if (cmd.size)
        begin
            nd_reg <= nd_calc;
        end
        if (cmd.plan)
        begin
            nz_reg  <= nz_calc;
            pad_reg <= pad_calc;
            rem_reg <= total;
        end
        if (cmd.emit)
        begin
            char_reg <= emit_char;
            last_reg <= (rem_reg == CW'(1));
            rem_reg  <= rem_reg - CW'(1);
            case (cmd.emit_sel)
                EM_SPACE: pad_reg <= pad_reg - CW'(1);
                EM_FILL:  pad_reg <= pad_reg - CW'(1);
                EM_PREC:  nz_reg  <= nz_reg - CW'(1);
                EM_DIGIT: nd_reg  <= nd_reg - DCNT_W'(1);
                default:  ;
            endcase
        end
    end

    // Control: step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                iter_reg <= '0;
            end
            else if (cmd.conv_step)
            begin
                iter_reg <= iter_reg + IT_W'(1);
            end
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.conv_done = (iter_reg == {IT_W{1'b1}});
        sts.pad_zero  = (pad_reg == '0);
        sts.prec_zero = (nz_reg == '0);
        sts.dig_zero  = (nd_reg == '0);
        sts.has_sign  = has_sign;
        sts.left      = left_reg;
        sts.zfill     = zfill_reg;
        sts.out_free  = out_free;
    end

    assign out_valid = valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

### hdl/signed_decimal_formatter.sv
// Signed decimal formatter: takes one integer with its printf %d flags on din
// and sends its decimal text on dout, one ASCII character per item, with last
// set on the final character. The integer is sign-extended from 32, 16, 8 or
// 64 bits by size_mode. A sign ('-', or '+'/' ' by the flags), zeros up to the
// precision, the digits, and padding up to the width (spaces left or right, or
// zeros after the sign) make up the text; the zero flag is ignored when a
// precision is given, and width and precision saturate at FIELD_MAX. An
// explicit zero precision with value 0 prints no digits, so a conversion may
// send no item at all. One item is worked on at a time: capture, then the
// shift-and-add-3 binary-to-BCD converter, then sizing and layout; then the
// characters leave at one per cycle while dout is ready, and empty text
// sections are stepped over. The text holds at most FIELD_MAX + 1
// characters. The next item is taken once the last character is in the
// output register and the sequencer is back in idle, even while that
// character still waits on dout.
`default_nettype none
module signed_decimal_formatter
    import sdf_pkg::*;
#(
    parameter int FIELD_MAX = 63
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sdf_in_if.sink     din,
    sdf_out_if.source  dout
);

    sdf_cmd_t cmd;
    sdf_sts_t sts;
    logic     in_ready;

    // Sequencer: walks the conversion and the text sections
    sdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Operand capture, BCD converter, layout counters and output register
    sdf_dp #(
        .FIELD_MAX (FIELD_MAX)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .value           (din.value),
        .size_mode       (din.size_mode),
        .force_sign      (din.force_sign),
        .space_sign      (din.space_sign),
        .left_align      (din.left_align),
        .zero_pad        (din.zero_pad),
        .precision_given (din.precision_given),
        .precision       (din.precision),
        .width           (din.width),
        .out_valid       (dout.valid),
        .out_ready       (dout.ready),
        .char_code       (dout.char_code),
        .last            (dout.last)
    );

    // Input is taken only between conversions
    assign din.ready = in_ready;

endmodule
`default_nettype wire

### hdl/sdf_checker.sv
`default_nettype none
`include "signed_decimal_formatter_macros.svh"
module sdf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] char_code,
    input wire logic       last
);

    // A stalled character holds
    `SDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last), "dout changed while stalled")

    // One item at a time: busy right after an item is taken
    `SDF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "din ready right after an item was taken")

    // No new item while a conversion still has characters to send
    `SDF_ASSERT_NOW(a_no_take_mid_text, out_valid && !last, !in_ready, "din ready in the middle of a conversion")

    // Only sign, space and digit characters appear
    `SDF_ASSERT_NOW(a_char_set, out_valid, (char_code == 8'h20) || (char_code == 8'h2B) || (char_code == 8'h2D) || ((char_code >= 8'h30) && (char_code <= 8'h39)), "unexpected character code")

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .char_code (dout.char_code),
    .last      (dout.last)
);
`default_nettype wire

### dv/signed_decimal_formatter_tb.sv
`timescale 1ns / 1ps
module signed_decimal_formatter_tb
    import sdf_pkg::*;
();

    // Field limit of the block under test (its parameter default).
    localparam int FIELD_MAX = 63;

    // Timeout budget. The slowest correct item is its conversion plus 64
    // characters that each wait out the longest sink stall and are then taken,
    // plus the longest source gap, for about 270 items. Add the long sink hold
    // and take it several times over.
    localparam int CYCLE_LIMIT = 1_500_000;

    // Cycles to wait after the last expected character. This covers an item
    // in flight that produces no text at all.
    localparam int SETTLE_CYCLES = 150;

    // Long sink hold for the backpressure test, in cycles.
    localparam int HOLD_CYCLES = 800;

    localparam int MAX_REPORTS = 10;

    // One conversion request, one field per input of the block.
    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         size_mode;
        logic               force_sign;
        logic               space_sign;
        logic               left_align;
        logic               zero_pad;
        logic               precision_given;
        logic [5:0]         precision;
        logic [5:0]         width;
    } conv_req_t;

    // One character of formatted text as it should leave the block.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } text_char_t;

    // Kinds of random values, picked to reach all the digit counts and edges.
    typedef enum int {
        VK_FULL,
        VK_SMALL,
        VK_EDGE,
        VK_ZERO,
        VK_POW10
    } value_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    sdf_in_if  din_bus();
    sdf_out_if dout_bus();

    signed_decimal_formatter #(
        .FIELD_MAX (FIELD_MAX)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_bus),
        .dout  (dout_bus)
    );

    // Characters the block still owes us, oldest first.
    text_char_t expected_chars[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idle controls. When set, the matching side never pauses. The hold count
    // forces the sink low for a long stretch.
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int hold_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Text predictor: build the printf %d text for one request and queue
    // its characters, marking the final one.
    // ------------------------------------------------------------------
    function automatic void predict_text(input conv_req_t req);
        logic [63:0] ext;
        logic [63:0] mag;
        logic        neg;
        logic        has_sign;
        logic        zfill;
        logic [7:0]  sign_char;
        logic [7:0]  digs[20];
        logic [7:0]  text[$];
        int          prec;
        int          wid;
        int          nd;
        int          nz;
        int          body;
        int          pad;
        text_char_t  ch;

        // Sign-extend from the selected argument size.
        case (req.size_mode)
            SZ_INT:   ext = {{32{req.value[31]}}, req.value[31:0]};
            SZ_SHORT: ext = {{48{req.value[15]}}, req.value[15:0]};
            SZ_CHAR:  ext = {{56{req.value[7]}}, req.value[7:0]};
            default:  ext = req.value;
        endcase

        // Take the magnitude in unsigned arithmetic so the most negative value
        // comes out exactly.
        neg = ext[63];
        mag = neg ? 64'd0 - ext : ext;

        prec = (req.precision > FIELD_MAX) ? FIELD_MAX : int'(req.precision);
        wid  = (req.width > FIELD_MAX) ? FIELD_MAX : int'(req.width);

        // Collect digits, least significant first. An explicit zero precision
        // with a zero value prints no digits.
        nd = 0;
        if (!(req.precision_given && prec == 0 && mag == 64'd0))
        begin
            do
            begin
                digs[nd] = ASCII_ZERO + 8'(mag % 64'd10);
                mag = mag / 64'd10;
                nd++;
            end while (mag != 64'd0 && nd < 20);
        end

        has_sign  = 1'b1;
        sign_char = ASCII_MINUS;
        if (!neg)
        begin
            if (req.force_sign)
                sign_char = ASCII_PLUS;
            else if (req.space_sign)
                sign_char = ASCII_SPACE;
            else
                has_sign = 1'b0;
        end

        nz   = (prec > nd) ? prec - nd : 0;
        body = int'(has_sign) + nz + nd;
        pad  = (wid > body) ? wid - body : 0;

        // Left-align wins over the zero flag, and a given precision drops it.
        zfill = !req.left_align && req.zero_pad && !req.precision_given;

        if (!req.left_align && !zfill)
            repeat (pad) text.push_back(ASCII_SPACE);
        if (has_sign)
            text.push_back(sign_char);
        if (zfill)
            repeat (pad) text.push_back(ASCII_ZERO);
        repeat (nz) text.push_back(ASCII_ZERO);
        for (int i = nd - 1; i >= 0; i--)
            text.push_back(digs[i]);
        if (req.left_align)
            repeat (pad) text.push_back(ASCII_SPACE);

        foreach (text[i])
        begin
            ch.char_code = text[i];
            ch.last      = (i == text.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic conv_req_t make_req(
        input logic [63:0] v,
        input logic [1:0]  sz,
        input logic        plus,
        input logic        space,
        input logic        left,
        input logic        zpad,
        input logic        pgiven,
        input logic [5:0]  prec,
        input logic [5:0]  wid
    );
        conv_req_t req;
        req.value           = v;
        req.size_mode       = sz;
        req.force_sign      = plus;
        req.space_sign      = space;
        req.left_align      = left;
        req.zero_pad        = zpad;
        req.precision_given = pgiven;
        req.precision       = prec;
        req.width           = wid;
        return req;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          s;
        value_kind_t kind;

        kind = value_kind_t'($urandom_range(0, 4));
        v    = 64'd0;
        case (kind)
            VK_FULL:
                v = {$urandom, $urandom};
            VK_SMALL:
            begin
                s = $urandom_range(0, 400);
                s = s - 200;
                v = {{32{s[31]}}, s};
            end
            VK_EDGE:
                // Range edges of every argument size, plus digit-count edges.
                case ($urandom_range(0, 15))
                    0:  v = 64'h0000_0000_0000_007F;
                    1:  v = 64'h0000_0000_0000_0080;
                    2:  v = 64'h0000_0000_0000_00FF;
                    3:  v = 64'h0000_0000_0000_7FFF;
                    4:  v = 64'h0000_0000_0000_8000;
                    5:  v = 64'h0000_0000_0000_FFFF;
                    6:  v = 64'h0000_0000_7FFF_FFFF;
                    7:  v = 64'h0000_0000_8000_0000;
                    8:  v = 64'h0000_0000_FFFF_FFFF;
                    9:  v = 64'h7FFF_FFFF_FFFF_FFFF;
                    10: v = 64'h8000_0000_0000_0000;
                    11: v = 64'hFFFF_FFFF_FFFF_FFFF;
                    12: v = 64'd9;
                    13: v = 64'd999_999_999_999_999_999;
                    14: v = 64'h8000_0000_0000_0001;
                    default: v = 64'd1;
                endcase
            VK_ZERO:
                v = 64'd0;
            default:
            begin
                p = 64'd1;
                repeat ($urandom_range(0, 18)) p = p * 64'd10;
                v = $urandom_range(0, 1) ? 64'd0 - p : p;
            end
        endcase
        return v;
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t   req;
        logic [63:0] upper;

        req.size_mode = 2'($urandom_range(0, 3));
        req.value     = random_value();

        // Bits above the argument size must not matter: scribble on them.
        case (req.size_mode)
            SZ_INT:   upper = 64'hFFFF_FFFF_0000_0000;
            SZ_SHORT: upper = 64'hFFFF_FFFF_FFFF_0000;
            SZ_CHAR:  upper = 64'hFFFF_FFFF_FFFF_FF00;
            default:  upper = 64'd0;
        endcase
        if ($urandom_range(0, 1))
            req.value = req.value | ({$urandom, $urandom} & upper);

        req.force_sign      = 1'($urandom_range(0, 1));
        req.space_sign      = 1'($urandom_range(0, 1));
        req.left_align      = 1'($urandom_range(0, 1));
        req.zero_pad        = 1'($urandom_range(0, 1));
        req.precision_given = 1'($urandom_range(0, 1));

        // Keep most fields short; now and then use the whole range.
        req.precision = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 6));
        req.width     = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 16));
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Source side. Hold valid high across back-to-back items; drop it only
    // for a gap, so valid never falls and rises in the same step. Predict at
    // the edge that accepts the item.
    // ------------------------------------------------------------------
    task automatic send_item(input conv_req_t req);
        int gap;

        gap = src_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            din_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_bus.value           <= req.value;
        din_bus.size_mode       <= req.size_mode;
        din_bus.force_sign      <= req.force_sign;
        din_bus.space_sign      <= req.space_sign;
        din_bus.left_align      <= req.left_align;
        din_bus.zero_pad        <= req.zero_pad;
        din_bus.precision_given <= req.precision_given;
        din_bus.precision       <= req.precision;
        din_bus.width           <= req.width;
        din_bus.valid           <= 1'b1;
        do @(posedge clk); while (!din_bus.ready);
        predict_text(req);
    endtask

    // Drop valid, wait until every owed character has arrived, then let the
    // block finish any item that produces no text.
    task automatic wait_idle();
        din_bus.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every size mode, every flag and the special cases.
    task automatic test_directed();
        // Zero with explicit zero precision: no text at all, then pad only,
        // then sign only, then sign with right pad.
        send_item(make_req(64'd0, SZ_INT,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0, 6'd0));
        send_item(make_req(64'd0, SZ_INT,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0, 6'd5));
        send_item(make_req(64'd0, SZ_LONG,  1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0, 6'd0));
        send_item(make_req(64'd0, SZ_SHORT, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 6'd0, 6'd3));
        // Zero with no precision still prints one digit.
        send_item(make_req(64'd0, SZ_INT,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        // Most negative and most positive 64-bit values.
        send_item(make_req(64'h8000_0000_0000_0000, SZ_LONG,
                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        send_item(make_req(64'h7FFF_FFFF_FFFF_FFFF, SZ_LONG,
                           1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        // 32-bit edges with junk in the upper half; space sign.
        send_item(make_req(64'hDEAD_BEEF_8000_0000, SZ_INT,
                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        send_item(make_req(64'h1234_5678_7FFF_FFFF, SZ_INT,
                           1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        // 16-bit edges; plus beats space.
        send_item(make_req(64'hFFFF_FFFF_FFFF_8000, SZ_SHORT,
                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        send_item(make_req(64'h0000_0000_ABCD_7FFF, SZ_SHORT,
                           1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        // 8-bit edges; zero fill; left-align beats the zero flag.
        send_item(make_req(64'h0000_0000_0000_0080, SZ_CHAR,
                           1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
        send_item(make_req(64'hFFFF_FFFF_FFFF_FF7F, SZ_CHAR,
                           1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0, 6'd6));
        send_item(make_req(64'h0000_0000_0000_00FF, SZ_CHAR,
                           1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 6'd0, 6'd8));
        // Zero fill goes after the minus sign.
        send_item(make_req(64'hFFFF_FFFF_FFFF_FFD6, SZ_LONG,
                           1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0, 6'd10));
        // A given precision turns the zero flag off: pad with spaces.
        send_item(make_req(64'd42, SZ_INT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 6'd4, 6'd10));
        // Precision counts even without precision_given.
        send_item(make_req(64'd7, SZ_INT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd5, 6'd0));
        // Longest text: sign plus 63 digits.
        send_item(make_req(64'h8000_0000_0000_0000, SZ_LONG,
                           1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd63, 6'd63));
        // Widest pad, on the right.
        send_item(make_req(64'd1, SZ_INT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 6'd63));
        // Every flag and both limits at once.
        send_item(make_req(64'd12345, SZ_LONG, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 6'd63, 6'd63));
        // Zero fill across the full width.
        send_item(make_req(64'd99, SZ_INT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0, 6'd63));
        send_item(make_req(64'hFFFF_FFFF_FFFF_FFFF, SZ_LONG,
                           1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0));
    endtask

    // Bulk random requests with random gaps on both sides.
    task automatic test_random(input int count);
        repeat (count) send_item(random_request());
    endtask

    // Neither side pauses: items arrive as fast as the block takes them.
    task automatic test_back_to_back(input int count);
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        repeat (count) send_item(random_request());
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // Hold the sink off for a long stretch while the source keeps offering
    // items back to back, so the block fills and stalls its input.
    task automatic test_output_backpressure(input int count);
        src_calm  = 1'b1;
        hold_left <= HOLD_CYCLES;
        repeat (count) send_item(random_request());
        src_calm  = 1'b0;
        wait_idle();
    endtask

    // Zero values with explicit zero precision: little or no text.
    task automatic test_empty_text(input int count);
        conv_req_t req;
        repeat (count)
        begin
            req                 = random_request();
            req.value           = req.value & 64'hFFFF_FFFF_FFFF_FF00;
            req.size_mode       = SZ_CHAR;
            req.precision_given = 1'b1;
            req.precision       = 6'd0;
            req.width           = 6'($urandom_range(0, 3));
            send_item(req);
        end
    endtask

    // ------------------------------------------------------------------
    // Sink side: draw a stall before every result, obey the long hold.
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int stall;
        dout_bus.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0 || hold_left != 0)
            begin
                dout_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_left != 0) @(posedge clk);
            end
            dout_bus.ready <= 1'b1;
            do @(posedge clk); while (!dout_bus.valid);
        end
    end

    // Count down the long hold.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted character with the oldest one
    // owed. Report the first few mismatches, count the rest.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_chars
        text_char_t want;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected char: got 0x%02h last %0b, nothing owed",
                             dout_bus.char_code, dout_bus.last);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (dout_bus.char_code !== want.char_code || dout_bus.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                                 want.char_code, want.last,
                                 dout_bus.char_code, dout_bus.last);
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("signed_decimal_formatter_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                   <= 1'b0;
        din_bus.valid           <= 1'b0;
        din_bus.value           <= '0;
        din_bus.size_mode       <= SZ_INT;
        din_bus.force_sign      <= 1'b0;
        din_bus.space_sign      <= 1'b0;
        din_bus.left_align      <= 1'b0;
        din_bus.zero_pad        <= 1'b0;
        din_bus.precision_given <= 1'b0;
        din_bus.precision       <= '0;
        din_bus.width           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(110);
        test_back_to_back(24);
        test_output_backpressure(16);
        test_empty_text(16);
        test_random(80);

        wait_idle();
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("signed_decimal_formatter_tb OK");
        else
            $display("signed_decimal_formatter_tb NOT OK");
        $finish;
    end

endmodule
